### src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Screen geometry, request and operation codes, queue entry layout and the
// status groups passed between front, queue and back.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Screen geometry
	localparam int SCREEN_WIDTH  = 80;
	localparam int SCREEN_HEIGHT = 25;
	localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;

	localparam int COL_W  = $clog2(SCREEN_WIDTH);
	localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int BIT_W  = $clog2(COL_W);
	localparam int TSUM_W = COL_W + 5;

	typedef logic [COL_W-1:0]  col_t;
	typedef logic [COL_W:0]    end_t;   // column count, can hold SCREEN_WIDTH
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [BIT_W-1:0]  bit_t;
	typedef logic [TSUM_W-1:0] tsum_t;
	typedef logic [15:0]       cell_t;  // {attr, char}

	localparam end_t  COL_END     = end_t'(SCREEN_WIDTH);
	localparam col_t  COL_LAST    = col_t'(SCREEN_WIDTH - 1);
	localparam row_t  ROW_LAST    = row_t'(SCREEN_HEIGHT - 1);
	localparam addr_t ADDR_LAST   = addr_t'(CELL_COUNT - 1);
	localparam addr_t ADDR_ROW1   = addr_t'(SCREEN_WIDTH);
	localparam addr_t ADDR_BOTTOM = addr_t'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH);
	localparam bit_t  BIT_TOP     = bit_t'(COL_W - 1);

	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam cell_t      BLANK_CELL = 16'h0F20;

	// Request codes
	localparam logic [1:0] REQ_PUT    = 2'd0;
	localparam logic [1:0] REQ_SETCUR = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;
	localparam logic [1:0] REQ_CLEAR  = 2'd3;

	// Control characters
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	// Configuration registers
	localparam logic [0:0] REG_PAD_ATTR = 1'd0;
	localparam logic [0:0] REG_TAB_STEP = 1'd1;
	localparam logic [7:0] PAD_ATTR_RST = 8'd15;
	localparam logic [4:0] TAB_STEP_RST = 5'd8;

	// Queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		OP_PRINT,
		OP_CR,
		OP_LF,
		OP_TAB,
		OP_BS,
		OP_SETCUR,
		OP_READ,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
		logic [7:0] attr;
		col_t       col;     // clamped set-cursor column
		row_t       row;     // clamped set-cursor row
		addr_t      idx;     // read address
		logic       idx_ok;  // read address on screen
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	typedef struct packed {
		logic init_busy;
	} back_status_t;

endpackage

### src/text_console_character_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_character_writer_core: text-mode console engine
// Character-and-attribute cell store with cursor; put character, set cursor,
// read cell and clear screen requests, one result per request.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): one request per transaction. The
//    front decodes it into a register stage, then into a 4-entry queue.
//  - Output channel (out_valid / out_stall): one result per request, in
//    request order, held in an output register until taken. While the
//    receiver stalls, the back holds its finished result and the front keeps
//    filling the queue, so intake stalls only once the queue backs up.
//  - Config port (cfg_we / cfg_index / cfg_data): pad attribute at index 0,
//    tab stop spacing at index 1; write only while the block is idle.
//  - Reset: cursor homes and a clearing pass writes every cell blank, one cell
//    a cycle over all CELL_COUNT (2000) cells; in_stall is high during that pass.
//  - A plain character, CR, set cursor: the request passes the front register
//    and the queue; the back then spends pop, execute and result steps on it,
//    and pops the next request only after loading the result.
//  - Newline and tab fill one cell a cycle over the span (tab first searches
//    for the stop, one column bit per step); read cell adds a read step.
//  - A scroll copies the store up one row at one cell a cycle and blanks the
//    bottom row. Clear screen blanks every cell, one cell a cycle.
// ----------------------------------------------------------------------------
module text_console_character_writer_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  char_code,
	input  logic [3:0]  fg_color,
	input  logic [3:0]  bg_color,
	input  logic [6:0]  new_col,
	input  logic [4:0]  new_row,
	input  logic [10:0] cell_index,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  cursor_col,
	output logic [4:0]  cursor_row,
	output logic [10:0] cursor_linear,
	output logic [7:0]  cell_char,
	output logic [7:0]  cell_attr,
	output logic        scrolled
);

	// front -> queue
	logic                   q_push;
	tcw_pkg::entry_t        q_entry;
	// queue -> back
	logic                   q_pop;
	tcw_pkg::entry_t        q_head;
	tcw_pkg::queue_status_t q_stat;
	// back -> front: intake held off during the reset clearing pass
	tcw_pkg::back_status_t  back_stat;

	tcw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.char_code  (char_code),
		.fg_color   (fg_color),
		.bg_color   (bg_color),
		.new_col    (new_col),
		.new_row    (new_row),
		.cell_index (cell_index),
		.back_stat  (back_stat),
		.q_stat     (q_stat),
		.q_push     (q_push),
		.q_entry    (q_entry)
	);

	tcw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop        (q_pop),
		.head       (q_head),
		.stat       (q_stat)
	);

	// back: cell store, cursor, config registers and result register
	tcw_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.head          (q_head),
		.q_stat        (q_stat),
		.q_pop         (q_pop),
		.stat          (back_stat),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.cursor_col    (cursor_col),
		.cursor_row    (cursor_row),
		.cursor_linear (cursor_linear),
		.cell_char     (cell_char),
		.cell_attr     (cell_attr),
		.scrolled      (scrolled)
	);

endmodule

### src/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front: request intake and decode
// Accepts input transactions, classifies them into operations, clamps the
// cursor target and range-checks the read address, then hands them to the queue.
// ----------------------------------------------------------------------------
module tcw_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             req_type,
	input  logic [7:0]             char_code,
	input  logic [3:0]             fg_color,
	input  logic [3:0]             bg_color,
	input  logic [6:0]             new_col,
	input  logic [4:0]             new_row,
	input  logic [10:0]            cell_index,
	input  tcw_pkg::back_status_t  back_stat,
	input  tcw_pkg::queue_status_t q_stat,
	output logic                   q_push,
	output tcw_pkg::entry_t        q_entry
);

	logic            valid_s1;
	tcw_pkg::entry_t entry_s1;
	tcw_pkg::entry_t dec;
	logic            accept;

	always_comb begin
		dec        = '0;
		dec.ch     = char_code;
		dec.attr   = {bg_color, fg_color};
		dec.col    = (int'(new_col) < tcw_pkg::SCREEN_WIDTH) ?
			tcw_pkg::col_t'(new_col) : tcw_pkg::COL_LAST;
		dec.row    = (int'(new_row) < tcw_pkg::SCREEN_HEIGHT) ?
			tcw_pkg::row_t'(new_row) : tcw_pkg::ROW_LAST;
		dec.idx    = tcw_pkg::addr_t'(cell_index);
		dec.idx_ok = int'(cell_index) < tcw_pkg::CELL_COUNT;
		unique case (req_type)
			tcw_pkg::REQ_PUT: begin
				unique case (char_code)
					tcw_pkg::CH_CR:  dec.op = tcw_pkg::OP_CR;
					tcw_pkg::CH_LF:  dec.op = tcw_pkg::OP_LF;
					tcw_pkg::CH_TAB: dec.op = tcw_pkg::OP_TAB;
					tcw_pkg::CH_BS:  dec.op = tcw_pkg::OP_BS;
					default:         dec.op = tcw_pkg::OP_PRINT;
				endcase
			end
			tcw_pkg::REQ_SETCUR: dec.op = tcw_pkg::OP_SETCUR;
			tcw_pkg::REQ_READ:   dec.op = tcw_pkg::OP_READ;
			tcw_pkg::REQ_CLEAR:  dec.op = tcw_pkg::OP_CLEAR;
		endcase
	end

	// hold off while the store is cleared after reset, or while the stage is stuck
	assign in_stall = back_stat.init_busy || (valid_s1 && q_stat.full);
	assign accept   = in_valid && !in_stall;
	assign q_push   = valid_s1 && !q_stat.full;
	assign q_entry  = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			entry_s1 <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				entry_s1 <= dec;
			end else if (q_push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

endmodule

### src/tcw_queue.sv
// ----------------------------------------------------------------------------
// tcw_queue: short request queue
// Small first-in first-out buffer of decoded requests between front and back.
// ----------------------------------------------------------------------------
module tcw_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  tcw_pkg::entry_t        push_entry,
	input  logic                   pop,
	output tcw_pkg::entry_t        head,
	output tcw_pkg::queue_status_t stat
);

	tcw_pkg::entry_t                slots_q [tcw_pkg::QUEUE_DEPTH];
	logic [tcw_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [tcw_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [tcw_pkg::QPTR_W:0]       count_q;
	logic                           do_push;
	logic                           do_pop;

	assign stat.full  = count_q == (tcw_pkg::QPTR_W + 1)'(tcw_pkg::QUEUE_DEPTH);
	assign stat.empty = count_q == '0;
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slots_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### src/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back: request execution
// Owns the cell store, the cursor and the configuration registers. Runs one
// request at a time: cell writes and reads, span fills, tab stop search, scroll
// copy, clear sweeps; then loads the result register.
// ----------------------------------------------------------------------------
module tcw_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [0:0]             cfg_index,
	input  logic [7:0]             cfg_data,
	input  tcw_pkg::entry_t        head,
	input  tcw_pkg::queue_status_t q_stat,
	output logic                   q_pop,
	output tcw_pkg::back_status_t  stat,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [6:0]             cursor_col,
	output logic [4:0]             cursor_row,
	output logic [10:0]            cursor_linear,
	output logic [7:0]             cell_char,
	output logic [7:0]             cell_attr,
	output logic                   scrolled
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_REM,
		ST_TABEND,
		ST_FILL,
		ST_BSWR,
		ST_WRAP,
		ST_COPY,
		ST_COPYLAST,
		ST_BLANK,
		ST_DONE
	} state_t;

	function automatic tcw_pkg::addr_t cell_addr(tcw_pkg::row_t r, tcw_pkg::col_t c);
		cell_addr = tcw_pkg::addr_t'(r) * tcw_pkg::addr_t'(tcw_pkg::SCREEN_WIDTH)
			+ tcw_pkg::addr_t'(c);
	endfunction

	tcw_pkg::cell_t  cells [tcw_pkg::CELL_COUNT];
	tcw_pkg::cell_t  rdata_q;

	state_t          state_q;
	logic            init_q;
	tcw_pkg::entry_t ent_q;
	tcw_pkg::col_t   cur_col_q;
	tcw_pkg::row_t   cur_row_q;
	tcw_pkg::addr_t  sweep_q;
	tcw_pkg::addr_t  waddr_q;
	logic            cp_v_q;
	tcw_pkg::end_t   fill_end_q;
	tcw_pkg::cell_t  fill_data_q;
	logic [4:0]      rem_q;
	tcw_pkg::bit_t   bit_q;
	logic [7:0]      pad_attr_q;
	logic [4:0]      tab_step_q;
	logic [7:0]      rd_char_q;
	logic [7:0]      rd_attr_q;
	logic            scrolled_q;

	logic            out_valid_q;
	logic [6:0]      out_col_q;
	logic [4:0]      out_row_q;
	logic [10:0]     out_lin_q;
	logic [7:0]      out_char_q;
	logic [7:0]      out_attr_q;
	logic            out_scr_q;

	logic            mem_we;
	tcw_pkg::addr_t  mem_waddr;
	tcw_pkg::cell_t  mem_wdata;
	tcw_pkg::addr_t  mem_raddr;
	tcw_pkg::addr_t  cur_addr;
	tcw_pkg::end_t   col_inc;
	logic [4:0]      tw_eff;
	logic [5:0]      rem_sh;
	logic [4:0]      rem_nx;
	tcw_pkg::tsum_t  tab_stop;
	tcw_pkg::end_t   tab_end;

	assign cur_addr = cell_addr(cur_row_q, cur_col_q);
	assign col_inc  = tcw_pkg::end_t'(cur_col_q) + tcw_pkg::end_t'(1);
	assign tw_eff   = (tab_step_q == '0) ? 5'd1 : tab_step_q;

	// restoring remainder, one column bit per step
	always_comb begin
		rem_sh = {rem_q, cur_col_q[bit_q]};
		if (rem_sh >= {1'b0, tw_eff})
			rem_sh = rem_sh - {1'b0, tw_eff};
		rem_nx = rem_sh[4:0];
	end

	assign tab_stop = tcw_pkg::tsum_t'(cur_col_q) + tcw_pkg::tsum_t'(tw_eff)
		- tcw_pkg::tsum_t'(rem_q);
	assign tab_end  = (tab_stop > tcw_pkg::tsum_t'(tcw_pkg::SCREEN_WIDTH)) ?
		tcw_pkg::COL_END : tcw_pkg::end_t'(tab_stop);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_addr;
		mem_wdata = fill_data_q;
		unique case (state_q)
			ST_EXEC: begin
				mem_we    = ent_q.op == tcw_pkg::OP_PRINT;
				mem_wdata = {ent_q.attr, ent_q.ch};
			end
			ST_FILL, ST_BSWR: mem_we = 1'b1;
			ST_CLEAR, ST_BLANK: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
				mem_wdata = tcw_pkg::BLANK_CELL;
			end
			ST_COPY, ST_COPYLAST: begin
				mem_we    = cp_v_q || state_q == ST_COPYLAST;
				mem_waddr = waddr_q;
				mem_wdata = rdata_q;
			end
			default: mem_we = 1'b0;
		endcase
	end

	assign mem_raddr = (state_q == ST_COPY) ? sweep_q : ent_q.idx;

	always_ff @(posedge clk) begin
		if (mem_we)
			cells[mem_waddr] <= mem_wdata;
		rdata_q <= cells[mem_raddr];
	end

	assign q_pop          = state_q == ST_IDLE && !q_stat.empty;
	assign stat.init_busy = init_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			init_q       <= 1'b1;
			ent_q        <= '0;
			cur_col_q    <= '0;
			cur_row_q    <= '0;
			sweep_q      <= '0;
			waddr_q      <= '0;
			cp_v_q       <= 1'b0;
			fill_end_q   <= '0;
			fill_data_q  <= '0;
			rem_q        <= '0;
			bit_q        <= '0;
			pad_attr_q   <= tcw_pkg::PAD_ATTR_RST;
			tab_step_q   <= tcw_pkg::TAB_STEP_RST;
			rd_char_q    <= '0;
			rd_attr_q    <= '0;
			scrolled_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			out_col_q    <= '0;
			out_row_q    <= '0;
			out_lin_q    <= '0;
			out_char_q   <= '0;
			out_attr_q   <= '0;
			out_scr_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tcw_pkg::REG_PAD_ATTR: pad_attr_q <= cfg_data;
					tcw_pkg::REG_TAB_STEP: tab_step_q <= cfg_data[4:0];
				endcase
			end

			// ST_DONE updates the result register itself
			if (out_valid_q && !out_stall && state_q != ST_DONE)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == tcw_pkg::ADDR_LAST) begin
						init_q  <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_DONE;
					end
				end
				ST_IDLE: begin
					if (!q_stat.empty) begin
						ent_q      <= head;
						rd_char_q  <= '0;
						rd_attr_q  <= '0;
						scrolled_q <= 1'b0;
						state_q    <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (ent_q.op)
						tcw_pkg::OP_PRINT: begin
							if (col_inc == tcw_pkg::COL_END) begin
								state_q <= ST_WRAP;
							end else begin
								cur_col_q <= tcw_pkg::col_t'(col_inc);
								state_q   <= ST_DONE;
							end
						end
						tcw_pkg::OP_CR: begin
							cur_col_q <= '0;
							state_q   <= ST_DONE;
						end
						tcw_pkg::OP_LF: begin
							fill_end_q  <= tcw_pkg::COL_END;
							fill_data_q <= {ent_q.attr, tcw_pkg::SPACE_CHAR};
							state_q     <= ST_FILL;
						end
						tcw_pkg::OP_TAB: begin
							fill_data_q <= {pad_attr_q, tcw_pkg::SPACE_CHAR};
							rem_q       <= '0;
							bit_q       <= tcw_pkg::BIT_TOP;
							state_q     <= ST_REM;
						end
						tcw_pkg::OP_BS: begin
							fill_data_q <= {pad_attr_q, tcw_pkg::SPACE_CHAR};
							if (cur_col_q == '0 && cur_row_q == '0) begin
								state_q <= ST_DONE;   // at home: no change
							end else begin
								if (cur_col_q == '0) begin
									cur_col_q <= tcw_pkg::COL_LAST;
									cur_row_q <= cur_row_q - 1'b1;
								end else begin
									cur_col_q <= cur_col_q - 1'b1;
								end
								state_q <= ST_BSWR;
							end
						end
						tcw_pkg::OP_SETCUR: begin
							cur_col_q <= ent_q.col;
							cur_row_q <= ent_q.row;
							state_q   <= ST_DONE;
						end
						tcw_pkg::OP_READ: begin
							state_q <= ent_q.idx_ok ? ST_READ : ST_DONE;
						end
						tcw_pkg::OP_CLEAR: begin
							sweep_q <= '0;
							state_q <= ST_CLEAR;
						end
					endcase
				end
				ST_READ: begin
					rd_char_q <= rdata_q[7:0];
					rd_attr_q <= rdata_q[15:8];
					state_q   <= ST_DONE;
				end
				ST_REM: begin
					rem_q <= rem_nx;
					if (bit_q == '0)
						state_q <= ST_TABEND;
					else
						bit_q <= bit_q - 1'b1;
				end
				ST_TABEND: begin
					fill_end_q <= tab_end;
					state_q    <= ST_FILL;
				end
				ST_FILL: begin
					if (col_inc == fill_end_q) begin
						if (fill_end_q == tcw_pkg::COL_END) begin
							state_q <= ST_WRAP;
						end else begin
							cur_col_q <= tcw_pkg::col_t'(col_inc);
							state_q   <= ST_DONE;
						end
					end else begin
						cur_col_q <= tcw_pkg::col_t'(col_inc);
					end
				end
				ST_BSWR: state_q <= ST_DONE;
				ST_WRAP: begin
					cur_col_q <= '0;
					if (cur_row_q != tcw_pkg::ROW_LAST) begin
						cur_row_q <= cur_row_q + 1'b1;
						state_q   <= ST_DONE;
					end else begin
						sweep_q <= tcw_pkg::ADDR_ROW1;
						waddr_q <= '0;
						cp_v_q  <= 1'b0;
						state_q <= ST_COPY;
					end
				end
				ST_COPY: begin
					// read one row ahead, write the previous read in the following cycle
					cp_v_q  <= 1'b1;
					if (cp_v_q)
						waddr_q <= waddr_q + 1'b1;
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == tcw_pkg::ADDR_LAST)
						state_q <= ST_COPYLAST;
				end
				ST_COPYLAST: begin
					sweep_q <= tcw_pkg::ADDR_BOTTOM;
					state_q <= ST_BLANK;
				end
				ST_BLANK: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == tcw_pkg::ADDR_LAST) begin
						scrolled_q <= 1'b1;
						state_q    <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_col_q   <= 7'(cur_col_q);
						out_row_q   <= 5'(cur_row_q);
						out_lin_q   <= 11'(cur_addr);
						out_char_q  <= rd_char_q;
						out_attr_q  <= rd_attr_q;
						out_scr_q   <= scrolled_q;
						state_q     <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign cursor_col    = out_col_q;
	assign cursor_row    = out_row_q;
	assign cursor_linear = out_lin_q;
	assign cell_char     = out_char_q;
	assign cell_attr     = out_attr_q;
	assign scrolled      = out_scr_q;

endmodule
